### rtl/core/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// Shared types, constants and the control store of the melody sequencer.
// ----------------------------------------------------------------------------
package swms_pkg;

  // note table
  localparam int NOTE_AW = 6;
  localparam int MAX_NOTES = 1 << NOTE_AW;

  // configuration register indexes
  localparam logic REG_MELODY_LENGTH = 1'b0;
  localparam logic REG_PAUSE_SCALE = 1'b1;

  localparam logic [6:0] MELODY_LENGTH_RESET = 7'd1;
  localparam logic [9:0] PAUSE_SCALE_RESET = 10'd333;

  // half period is 1000000 / freq / 2, taken as 500000 / freq
  localparam logic [31:0] HALF_DIVIDEND = 32'd500000;
  // x / 1000 as (x * ceil(2^38 / 1000)) >> 38, exact for any 32-bit x
  localparam logic [28:0] MS_RECIP = 29'd274877907;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // shared divider
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW = 6;

  localparam int UPC_W = 5;

  typedef enum logic [2:0] {
    PH_SELECT = 3'd0,
    PH_NEXT = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW = 3'd3,
    PH_PAUSE = 3'd4
  } phase_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRAP,
    OP_READ,
    OP_SEL_CHECK,
    OP_DIV_HALF,
    OP_HALF_STORE,
    OP_CYC_STORE,
    OP_NEXT,
    OP_COUNT,
    OP_HIGH_END,
    OP_LOW_END,
    OP_PMUL,
    OP_PSCALE,
    OP_PAUSE_END,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    C_STEP,
    C_DIV_BUSY,
    C_FREQ_ZERO
  } cond_t;

  typedef struct packed {
    op_t op;
    cond_t cond;
    logic [UPC_W-1:0] target;
    logic last;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  // program entry points
  localparam logic [UPC_W-1:0] A_SELECT = 5'd0;
  localparam logic [UPC_W-1:0] A_HALF_WAIT = 5'd4;
  localparam logic [UPC_W-1:0] A_DONE = 5'd7;
  localparam logic [UPC_W-1:0] A_NEXT = 5'd8;
  localparam logic [UPC_W-1:0] A_HIGH = 5'd9;
  localparam logic [UPC_W-1:0] A_LOW = 5'd11;
  localparam logic [UPC_W-1:0] A_PAUSE = 5'd13;
  localparam logic [UPC_W-1:0] A_BAD = 5'd18;

  function automatic ucode_t uword(op_t op, cond_t cond, logic [UPC_W-1:0] target,
                                   logic last);
    ucode_t w;
    w.op = op;
    w.cond = cond;
    w.target = target;
    w.last = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [UPC_W-1:0] upc);
    ucode_t w;
    case (upc)
      // select note
      5'd0: w = uword(OP_WRAP, C_STEP, A_SELECT, 1'b0);
      5'd1: w = uword(OP_READ, C_STEP, A_SELECT, 1'b0);
      5'd2: w = uword(OP_SEL_CHECK, C_FREQ_ZERO, A_DONE, 1'b0);
      5'd3: w = uword(OP_DIV_HALF, C_STEP, A_SELECT, 1'b0);
      5'd4: w = uword(OP_NONE, C_DIV_BUSY, A_HALF_WAIT, 1'b0);
      5'd5: w = uword(OP_HALF_STORE, C_STEP, A_SELECT, 1'b0);
      5'd6: w = uword(OP_CYC_STORE, C_STEP, A_SELECT, 1'b1);
      // rest note and write requests end here
      5'd7: w = uword(OP_NONE, C_STEP, A_SELECT, 1'b1);
      // next cycle
      5'd8: w = uword(OP_NEXT, C_STEP, A_SELECT, 1'b1);
      // high half
      5'd9: w = uword(OP_COUNT, C_STEP, A_SELECT, 1'b0);
      5'd10: w = uword(OP_HIGH_END, C_STEP, A_SELECT, 1'b1);
      // low half
      5'd11: w = uword(OP_COUNT, C_STEP, A_SELECT, 1'b0);
      5'd12: w = uword(OP_LOW_END, C_STEP, A_SELECT, 1'b1);
      // pause, length read live from the table
      5'd13: w = uword(OP_COUNT, C_STEP, A_SELECT, 1'b0);
      5'd14: w = uword(OP_READ, C_STEP, A_SELECT, 1'b0);
      5'd15: w = uword(OP_PMUL, C_STEP, A_SELECT, 1'b0);
      5'd16: w = uword(OP_PSCALE, C_STEP, A_SELECT, 1'b0);
      5'd17: w = uword(OP_PAUSE_END, C_STEP, A_SELECT, 1'b1);
      5'd18: w = uword(OP_BAD, C_STEP, A_SELECT, 1'b1);
      default: w = uword(OP_BAD, C_STEP, A_SELECT, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] start_addr(phase_t ph);
    logic [UPC_W-1:0] a;
    case (ph)
      PH_SELECT: a = A_SELECT;
      PH_NEXT: a = A_NEXT;
      PH_HIGH: a = A_HIGH;
      PH_LOW: a = A_LOW;
      PH_PAUSE: a = A_PAUSE;
      default: a = A_BAD;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/swms_req_if.sv
// ----------------------------------------------------------------------------
// swms_req_if
// Request channel: microsecond ticks and note table writes.
// ----------------------------------------------------------------------------
interface swms_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [5:0] entry_index;
  logic [15:0] entry_freq;
  logic [15:0] entry_length;

  modport source (output valid, output cmd, output entry_index, output entry_freq,
                  output entry_length, input ready);
  modport sink (input valid, input cmd, input entry_index, input entry_freq,
                input entry_length, output ready);
endinterface

### rtl/core/swms_res_if.sv
// ----------------------------------------------------------------------------
// swms_res_if
// Result channel: pin level, note index and phase after each request.
// ----------------------------------------------------------------------------
interface swms_res_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic [5:0] playing_note;
  logic [2:0] phase;

  modport source (output valid, output pin_level, output playing_note, output phase,
                  input ready);
  modport sink (input valid, input pin_level, input playing_note, input phase,
                output ready);
endinterface

### rtl/core/square_wave_melody_sequencer_core.sv
// ----------------------------------------------------------------------------
// square_wave_melody_sequencer_core
// Buzzer melody player stepped by one-microsecond tick requests.
// ----------------------------------------------------------------------------
// Each request gives one result and holds the input from its accept cycle
// until its program has ended, a span that depends on the request and the
// phase: a table write runs only the final step; a tick runs a short
// microprogram, where selecting a sounding note waits on one 32-step pass
// through the bit-serial divider for the half period (the cycle count divides
// by 1000 with a reciprocal multiply) and selecting a rest ends after its
// check. A stalled result side adds its stall to the last step.
// The next request is taken once the program has ended, even while the last
// result still waits in the output register. The note table has no reset: a
// note must be written before it is played.
module square_wave_melody_sequencer_core (
  input  logic clk,
  input  logic rst,
  swms_req_if.sink request,
  swms_res_if.source result,
  input  logic cfg_write,
  input  logic cfg_index,
  input  logic [9:0] cfg_data
);

  // configuration
  logic [6:0] melody_length;
  logic [9:0] pause_scale;

  // sequencer
  swms_pkg::seq_state_t state, state_next;
  logic [swms_pkg::UPC_W-1:0] upc, upc_next;
  swms_pkg::ucode_t uw;
  logic accept;
  logic out_free;
  logic exec;
  logic jump;

  // datapath
  logic [31:0] note_mem [swms_pkg::MAX_NOTES];
  logic [31:0] rdata;
  logic mem_read;
  logic [swms_pkg::NOTE_AW-1:0] pointer, pointer_next;
  logic [31:0] cycles_done, cycles_done_next;
  logic [31:0] cycles_target, cycles_target_next;
  logic [18:0] half_period, half_period_next;
  logic [31:0] elapsed, elapsed_next;
  swms_pkg::phase_t phase, phase_next;
  logic level, level_next;
  logic [25:0] pause_prod;
  logic [27:0] pause_us;
  logic [31:0] cyc_prod;
  logic [60:0] cyc_scaled;
  logic [15:0] freq;
  logic [15:0] len;

  swms_pkg::div_req_t div_req;
  logic div_busy;
  logic [31:0] div_quo;

  swms_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .busy(div_busy),
    .quotient(div_quo)
  );

  assign freq = rdata[31:16];
  assign len = rdata[15:0];
  assign uw = swms_pkg::ucode_rom(upc);
  assign accept = request.valid && request.ready;
  assign out_free = !result.valid || result.ready;
  // a final step waits until the output register can take its result
  assign exec = (state == swms_pkg::SEQ_RUN) && (!uw.last || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      melody_length <= swms_pkg::MELODY_LENGTH_RESET;
      pause_scale <= swms_pkg::PAUSE_SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        swms_pkg::REG_MELODY_LENGTH: melody_length <= cfg_data[6:0];
        swms_pkg::REG_PAUSE_SCALE: pause_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      swms_pkg::SEQ_IDLE: begin
        if (accept) state_next = swms_pkg::SEQ_RUN;
      end
      swms_pkg::SEQ_RUN: begin
        if (exec && uw.last) state_next = swms_pkg::SEQ_IDLE;
      end
      default: state_next = swms_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    request.ready = 1'b0;
    case (state)
      swms_pkg::SEQ_IDLE: request.ready = 1'b1;
      swms_pkg::SEQ_RUN: request.ready = 1'b0;
      default: request.ready = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.cond)
      swms_pkg::C_STEP: jump = 1'b0;
      swms_pkg::C_DIV_BUSY: jump = div_busy;
      swms_pkg::C_FREQ_ZERO: jump = (freq == '0);
      default: jump = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (accept) begin
      upc_next = request.cmd ? swms_pkg::A_DONE : swms_pkg::start_addr(phase);
    end else if (exec && !uw.last) begin
      upc_next = jump ? uw.target : upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swms_pkg::SEQ_IDLE;
      upc <= swms_pkg::A_SELECT;
    end else begin
      state <= state_next;
      upc <= upc_next;
    end
  end

  // note table
  assign mem_read = exec && (uw.op == swms_pkg::OP_READ);

  always_ff @(posedge clk) begin
    if (accept && request.cmd) begin
      note_mem[request.entry_index] <= {request.entry_freq, request.entry_length};
    end
    if (mem_read) begin
      rdata <= note_mem[pointer];
    end
  end

  // cycle count: freq * len / 1000 by reciprocal multiply
  assign cyc_scaled = cyc_prod * swms_pkg::MS_RECIP;

  // datapath operations
  always_comb begin
    pointer_next = pointer;
    cycles_done_next = cycles_done;
    cycles_target_next = cycles_target;
    half_period_next = half_period;
    elapsed_next = elapsed;
    phase_next = phase;
    level_next = level;
    div_req.start = 1'b0;
    div_req.dividend = swms_pkg::HALF_DIVIDEND;
    div_req.divisor = freq;
    if (exec) begin
      case (uw.op)
        swms_pkg::OP_WRAP: begin
          if ({1'b0, pointer} >= melody_length) pointer_next = '0;
        end
        swms_pkg::OP_SEL_CHECK: begin
          elapsed_next = '0;
          if (freq == '0) phase_next = swms_pkg::PH_PAUSE;
        end
        swms_pkg::OP_DIV_HALF: begin
          div_req.start = 1'b1;
        end
        swms_pkg::OP_HALF_STORE: begin
          half_period_next = div_quo[18:0];
        end
        swms_pkg::OP_CYC_STORE: begin
          cycles_target_next = {9'd0, cyc_scaled[60:38]};
          cycles_done_next = '0;
          phase_next = swms_pkg::PH_NEXT;
        end
        swms_pkg::OP_NEXT: begin
          elapsed_next = '0;
          if (cycles_done < cycles_target) begin
            level_next = 1'b1;
            phase_next = swms_pkg::PH_HIGH;
          end else begin
            level_next = 1'b0;
            phase_next = swms_pkg::PH_PAUSE;
          end
        end
        swms_pkg::OP_COUNT: begin
          if (elapsed != '1) elapsed_next = elapsed + 1'b1;
        end
        swms_pkg::OP_HIGH_END: begin
          if (elapsed >= {13'd0, half_period}) begin
            level_next = 1'b0;
            elapsed_next = '0;
            phase_next = swms_pkg::PH_LOW;
          end
        end
        swms_pkg::OP_LOW_END: begin
          if (elapsed >= {13'd0, half_period}) begin
            cycles_done_next = cycles_done + 1'b1;
            phase_next = swms_pkg::PH_NEXT;
          end
        end
        swms_pkg::OP_PAUSE_END: begin
          if (elapsed >= {4'd0, pause_us}) begin
            // table depth is a power of two, so the pointer wraps by itself
            pointer_next = pointer + 1'b1;
            phase_next = swms_pkg::PH_SELECT;
          end
        end
        swms_pkg::OP_BAD: begin
          phase_next = swms_pkg::PH_SELECT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer <= '0;
      cycles_done <= '0;
      cycles_target <= '0;
      half_period <= '0;
      elapsed <= '0;
      phase <= swms_pkg::PH_SELECT;
      level <= 1'b0;
    end else begin
      pointer <= pointer_next;
      cycles_done <= cycles_done_next;
      cycles_target <= cycles_target_next;
      half_period <= half_period_next;
      elapsed <= elapsed_next;
      phase <= phase_next;
      level <= level_next;
    end
  end

  // freq * len, taken while the divider starts
  always_ff @(posedge clk) begin
    if (exec && (uw.op == swms_pkg::OP_DIV_HALF)) begin
      cyc_prod <= freq * len;
    end
  end

  // pause length: (len * factor) >> 8, then ms to us
  always_ff @(posedge clk) begin
    if (exec && (uw.op == swms_pkg::OP_PMUL)) begin
      pause_prod <= len * pause_scale;
    end
    if (exec && (uw.op == swms_pkg::OP_PSCALE)) begin
      pause_us <= pause_prod[25:8] * swms_pkg::US_PER_MS;
    end
  end

  // output register, loaded with the state after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (exec && uw.last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && uw.last) begin
      result.pin_level <= level_next;
      result.playing_note <= pointer_next;
      result.phase <= phase_next;
    end
  end

endmodule

### rtl/core/swms_div.sv
// ----------------------------------------------------------------------------
// swms_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module swms_div (
  input  logic clk,
  input  logic rst,
  input  swms_pkg::div_req_t req,
  output logic busy,
  output logic [31:0] quotient
);

  logic [swms_pkg::DIV_CW-1:0] count;
  logic [15:0] divisor;
  logic [15:0] rem;
  logic [16:0] trial;
  logic [16:0] diff;

  assign busy = (count != '0);
  assign trial = {rem, quotient[31]};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.start) begin
      count <= swms_pkg::DIV_CW'(swms_pkg::DIV_STEPS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      quotient <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      // trial fits below twice the divisor, so one subtract decides the bit
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[15:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

### verif/square_wave_melody_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// square_wave_melody_sequencer_core_tb
// Drives tick and note write requests through the melody sequencer, predicts
// pin level, note index and phase for every request, and compares each result
// in order. Runs several register settings under varied idle and stall rates.
// ----------------------------------------------------------------------------
module square_wave_melody_sequencer_core_tb;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned PHASE_TICK_BUDGET = 1100;

  typedef struct packed {
    logic pin_level;
    logic [5:0] playing_note;
    logic [2:0] phase;
  } player_view_t;

  class melody_scoreboard;
    logic [31:0] notes [swms_pkg::MAX_NOTES];
    bit written [swms_pkg::MAX_NOTES];
    logic [5:0] ptr;
    logic [31:0] cycles_done;
    logic [31:0] cycles_target;
    logic [31:0] elapsed;
    logic [18:0] half_period;
    swms_pkg::phase_t fsm;
    logic level;
    logic [6:0] ml;
    logic [9:0] pf;
    player_view_t expected_views[$];
    int errors;

    function new();
      for (int i = 0; i < swms_pkg::MAX_NOTES; i++) begin
        notes[i] = '0;
        written[i] = 1'b0;
      end
      ptr = '0;
      cycles_done = '0;
      cycles_target = '0;
      elapsed = '0;
      half_period = '0;
      fsm = swms_pkg::PH_SELECT;
      level = 1'b0;
      ml = swms_pkg::MELODY_LENGTH_RESET;
      pf = swms_pkg::PAUSE_SCALE_RESET;
      errors = 0;
    endfunction

    function void write_register(logic idx, logic [9:0] value);
      if (idx == swms_pkg::REG_MELODY_LENGTH) ml = value[6:0];
      else pf = value;
    endfunction

    // pause length of the current note, read live from the table
    function logic [63:0] pause_length_us();
      return ((64'(notes[ptr][15:0]) * 64'(pf)) >> 8) * 64'd1000;
    endfunction

    function int outstanding();
      return expected_views.size();
    endfunction

    function void note_request(logic c, logic [5:0] idx, logic [15:0] f, logic [15:0] l);
      logic [31:0] entry;
      player_view_t v;
      if (c == CMD_WRITE) begin
        notes[idx] = {f, l};
        written[idx] = 1'b1;
      end else begin
        case (fsm)
          swms_pkg::PH_SELECT: begin
            if ({1'b0, ptr} >= ml) ptr = '0;
            entry = notes[ptr];
            elapsed = '0;
            if (entry[31:16] == 16'd0) begin
              fsm = swms_pkg::PH_PAUSE;
            end else begin
              half_period = 19'((32'd1000000 / entry[31:16]) / 2);
              cycles_target = 32'((64'(entry[31:16]) * 64'(entry[15:0])) / 64'd1000);
              cycles_done = '0;
              fsm = swms_pkg::PH_NEXT;
            end
          end
          swms_pkg::PH_NEXT: begin
            elapsed = '0;
            if (cycles_done < cycles_target) begin
              level = 1'b1;
              fsm = swms_pkg::PH_HIGH;
            end else begin
              level = 1'b0;
              fsm = swms_pkg::PH_PAUSE;
            end
          end
          swms_pkg::PH_HIGH: begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= 32'(half_period)) begin
              level = 1'b0;
              elapsed = '0;
              fsm = swms_pkg::PH_LOW;
            end
          end
          swms_pkg::PH_LOW: begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= 32'(half_period)) begin
              cycles_done++;
              fsm = swms_pkg::PH_NEXT;
            end
          end
          swms_pkg::PH_PAUSE: begin
            if (elapsed != '1) elapsed++;
            if (64'(elapsed) >= pause_length_us()) begin
              ptr++;
              fsm = swms_pkg::PH_SELECT;
            end
          end
          default: fsm = swms_pkg::PH_SELECT;
        endcase
      end
      v.pin_level = level;
      v.playing_note = ptr;
      v.phase = fsm;
      expected_views.push_back(v);
    endfunction

    function void check_result(logic pin, logic [5:0] note, logic [2:0] ph);
      player_view_t want;
      if (expected_views.size() == 0) begin
        $error("result with no request outstanding: pin_level %0d playing_note %0d phase %0d",
               pin, note, ph);
        errors++;
        return;
      end
      want = expected_views.pop_front();
      if (pin !== want.pin_level) begin
        $error("pin_level: expected %0d, got %0d", want.pin_level, pin);
        errors++;
      end
      if (note !== want.playing_note) begin
        $error("playing_note: expected %0d, got %0d", want.playing_note, note);
        errors++;
      end
      if (ph !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, ph);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_index;
  logic [9:0] cfg_data;

  swms_req_if req_ch ();
  swms_res_if res_ch ();

  melody_scoreboard sb;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit hold_request;
  longint unsigned tone_budget;
  longint unsigned pause_allow;

  square_wave_melody_sequencer_core i_dut (
    .clk(clk),
    .rst(rst),
    .request(req_ch),
    .result(res_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ticks needed to play the tone part of a table entry
  function automatic longint unsigned tone_ticks(logic [31:0] entry);
    longint unsigned f;
    longint unsigned cycles;
    longint unsigned half;
    f = 64'(entry[31:16]);
    if (f == 0) return 0;
    cycles = (f * entry[15:0]) / 1000;
    half = (1000000 / f) / 2;
    return cycles * (2 * half + 1) + 1;
  endfunction

  task automatic send_request(input logic c, input logic [5:0] idx, input logic [15:0] f,
                              input logic [15:0] l);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c;
    req_ch.entry_index <= idx;
    req_ch.entry_freq <= f;
    req_ch.entry_length <= l;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(c, idx, f, l);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_registers(input logic [6:0] length, input logic [9:0] factor);
    cfg_write <= 1'b1;
    cfg_index <= swms_pkg::REG_MELODY_LENGTH;
    cfg_data <= {3'b000, length};
    @(posedge clk);
    sb.write_register(swms_pkg::REG_MELODY_LENGTH, {3'b000, length});
    cfg_index <= swms_pkg::REG_PAUSE_SCALE;
    cfg_data <= factor;
    @(posedge clk);
    sb.write_register(swms_pkg::REG_PAUSE_SCALE, factor);
    cfg_write <= 1'b0;
  endtask

  // rests, notes too short for a full cycle, and now and then a real tone
  task automatic write_melody_note(input logic [5:0] slot);
    logic [15:0] f;
    logic [15:0] l;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      f = 16'd0;
      l = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(3));
    end else if (kind < 35 && tone_budget >= PHASE_TICK_BUDGET) begin
      f = 16'($urandom_range(1000, 4000));
      l = 16'd1;
    end else begin
      f = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 999));
      l = 16'($urandom_range(0, 999 / f));
    end
    send_request(CMD_WRITE, slot, f, l);
  endtask

  task automatic send_next_item();
    logic [5:0] slot;
    longint unsigned cost;
    longint unsigned pause;
    int unsigned roll;
    cost = 0;
    if (sb.fsm == swms_pkg::PH_SELECT) begin
      slot = ({1'b0, sb.ptr} >= sb.ml) ? 6'd0 : sb.ptr;
      cost = tone_ticks(sb.notes[slot]);
      if (!sb.written[slot] || cost > tone_budget) begin
        write_melody_note(slot);
        return;
      end
    end
    if (sb.fsm == swms_pkg::PH_PAUSE) begin
      pause = sb.pause_length_us();
      if (pause > pause_allow) begin
        if (pause <= tone_budget) begin
          tone_budget -= pause;
          pause_allow = pause;
        end else begin
          // shorten the running pause by rewriting its entry
          send_request(CMD_WRITE, sb.ptr, sb.notes[sb.ptr][31:16], 16'd0);
          return;
        end
      end
    end
    roll = $urandom_range(99);
    if (roll < 10) begin
      send_request(CMD_WRITE, 6'($urandom), 16'($urandom), 16'($urandom));
    end else if (roll < 18) begin
      write_melody_note(6'($urandom));
    end else begin
      if (sb.fsm == swms_pkg::PH_SELECT) begin
        tone_budget -= cost;
        pause_allow = 300;
      end
      send_request(CMD_TICK, 6'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.pin_level, res_ch.playing_note, res_ch.phase);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [6:0] length;
    logic [9:0] factor;
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 1'b0;
    tone_budget = 0;
    pause_allow = 300;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_TICK;
    req_ch.entry_index = '0;
    req_ch.entry_freq = '0;
    req_ch.entry_length = '0;
    cfg_write = 1'b0;
    cfg_index = swms_pkg::REG_MELODY_LENGTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // rest with no pause, then a wrap back to note zero
    send_request(CMD_WRITE, 6'd0, 16'd0, 16'd0);
    send_request(CMD_WRITE, 6'd63, 16'hffff, 16'hffff);
    send_request(CMD_TICK, 6'd63, 16'hffff, 16'hffff);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    // highest frequency, too short for a single cycle
    send_request(CMD_WRITE, 6'd0, 16'hffff, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    // lowest frequency with a long pause cut short by a live rewrite
    send_request(CMD_WRITE, 6'd0, 16'd1, 16'd999);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_WRITE, 6'd0, 16'd1, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    // rest with the longest length
    send_request(CMD_WRITE, 6'd0, 16'd0, 16'hffff);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    send_request(CMD_WRITE, 6'd0, 16'd0, 16'd0);
    send_request(CMD_TICK, 6'd0, 16'd0, 16'd0);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          length = 7'd64;
          factor = 10'd0;
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          length = 7'd1;
          factor = 10'd1023;
          sender_idle_pct = 55;
          receiver_stall_pct = 0;
        end
        2: begin
          length = 7'($urandom_range(2, 12));
          factor = 10'($urandom_range(0, 1023));
          sender_idle_pct = 0;
          receiver_stall_pct = 55;
        end
        3: begin
          length = 7'd0;
          factor = 10'd255;
          sender_idle_pct = 25;
          receiver_stall_pct = 25;
        end
        default: begin
          length = 7'($urandom_range(3, 64));
          factor = 10'($urandom_range(0, 1023));
          sender_idle_pct = 25;
          receiver_stall_pct = 25;
        end
      endcase
      program_registers(length, factor);
      tone_budget = PHASE_TICK_BUDGET;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // result side backs up while requests keep coming
        if (p == 2 && n == 40) hold_request = 1'b1;
        send_next_item();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
